// File: sv/lpfmd_pkg.sv
`timescale 1ns / 1ps
package lpfmd_pkg;
  localparam int TimeW = 48;
  localparam int PowerW = 16;
  localparam int DurW = 16;
  localparam int IdxW = 4;
  localparam int ArrW = 32;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic OpLoad = 1'b0;
  localparam logic OpTask = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPick,
    StWrite,
    StOut
  } state_t;
endpackage

// File: sv/lowest_power_free_machine_dispatcher_core.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                                  | tuser
// s_axis  | in  | machine_index[3:0] power[19:4] enable[20] task_duration[36:21] | operation
// m_axis  | out | assigned_machine[3:0] start_at[51:4] finish_time[99:52]    | no_machine
// A load is taken without leaving StIdle; the next transaction can follow right after it.
// A task makes two passes over the memories: the first finds the earliest free time,
// the second picks the lowest-power free machine.
// A write-back state follows, then the result is held in StOut; the next input is taken
// only once the result has been accepted and the block is back in StIdle.
// Reset is synchronous; the memory holds no reset value, so a per-machine valid bit
// marks free times written since reset. A stalled result holds the block until taken.
module lowest_power_free_machine_dispatcher_core #(
  parameter int NUM_MACHINES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // machine_index, power, enable, task_duration
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // assigned_machine, start_at, finish_time
  output logic         m_axis_tuser   // no_machine
);
  localparam int MW = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
  localparam int CW = $clog2(NUM_MACHINES + 1);
  localparam int TW = lpfmd_pkg::TimeW;

  lpfmd_pkg::state_t state, state_next;

  logic [TW-1:0] free_mem [NUM_MACHINES];
  logic [lpfmd_pkg::PowerW-1:0] pow_mem [NUM_MACHINES];
  logic [NUM_MACHINES-1:0] en_flags, written;

  logic [TW-1:0] cur_time;
  logic [lpfmd_pkg::ArrW-1:0] arrived;
  logic [lpfmd_pkg::DurW-1:0] dur;
  logic [CW-1:0] cnt;
  logic [MW-1:0] rd_idx, rd_q;
  logic rd_vld;
  logic [TW-1:0] rd_free;
  logic [lpfmd_pkg::PowerW-1:0] rd_pow;
  logic any, found;
  logic [TW-1:0] earliest, now;
  logic [MW-1:0] best;
  logic [lpfmd_pkg::PowerW-1:0] best_pow;
  logic [TW-1:0] fin;
  logic [TW:0] sum;
  logic pass2;

  logic [lpfmd_pkg::IdxW-1:0] in_idx;
  assign in_idx = s_axis_tdata[3:0];
  logic in_ok;
  assign in_ok = ({{(32-lpfmd_pkg::IdxW){1'b0}}, in_idx} < 32'(NUM_MACHINES));
  logic [MW-1:0] in_m;
  assign in_m = MW'(in_idx);

  assign s_axis_tready = (state == lpfmd_pkg::StIdle) && !rst;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  assign rd_idx = MW'(cnt);

  always_ff @(posedge clk) begin
    if (acc && s_axis_tuser == lpfmd_pkg::OpLoad && in_ok)
      pow_mem[in_m] <= s_axis_tdata[19:4];
    if (state == lpfmd_pkg::StWrite && found)
      free_mem[best] <= fin;
    rd_free <= free_mem[rd_idx];
    rd_pow <= pow_mem[rd_idx];
    rd_q <= rd_idx;
  end

  logic [TW-1:0] f_val;
  assign f_val = written[rd_q] ? rd_free : '0;
  logic cand_en;
  assign cand_en = rd_vld && en_flags[rd_q];

  // base time after first pass
  logic [TW-1:0] base;
  assign base = (cur_time < TW'(arrived)) ? TW'(arrived) : cur_time;
  assign sum = {1'b0, now} + {{(TW+1-lpfmd_pkg::DurW){1'b0}}, dur};
  assign fin = sum[TW] ? lpfmd_pkg::TimeMax : sum[TW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      lpfmd_pkg::StIdle:
        if (acc && s_axis_tuser == lpfmd_pkg::OpTask) state_next = lpfmd_pkg::StScan;
      lpfmd_pkg::StScan:
        if (!rd_vld && cnt == CW'(NUM_MACHINES)) state_next = lpfmd_pkg::StPick;
      lpfmd_pkg::StPick:
        if (!rd_vld && cnt == CW'(NUM_MACHINES)) state_next = lpfmd_pkg::StWrite;
      lpfmd_pkg::StWrite: state_next = lpfmd_pkg::StOut;
      lpfmd_pkg::StOut:
        if (m_axis_tready) state_next = lpfmd_pkg::StIdle;
      default: state_next = lpfmd_pkg::StIdle;
    endcase
  end

  always_comb begin
    m_axis_tvalid = (state == lpfmd_pkg::StOut);
  end
  assign pass2 = (state == lpfmd_pkg::StPick);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpfmd_pkg::StIdle;
      en_flags <= '0;
      written <= '0;
      cur_time <= '0;
      arrived <= '0;
      cnt <= '0;
      rd_vld <= 1'b0;
      m_axis_tuser <= 1'b0;
      m_axis_tdata <= '0;
    end else begin
      state <= state_next;
      rd_vld <= 1'b0;
      if (acc) begin
        if (s_axis_tuser == lpfmd_pkg::OpLoad) begin
          if (in_ok) en_flags[in_m] <= s_axis_tdata[20];
        end else begin
          dur <= s_axis_tdata[36:21];
          cnt <= '0;
          any <= 1'b0;
        end
      end
      if (state == lpfmd_pkg::StScan || state == lpfmd_pkg::StPick) begin
        if (cnt != CW'(NUM_MACHINES)) begin
          cnt <= cnt + 1'b1;
          rd_vld <= 1'b1;
        end
        if (cand_en) begin
          if (!pass2) begin
            if (!any || f_val < earliest) earliest <= f_val;
            any <= 1'b1;
          end else if (f_val <= now && (!found || rd_pow < best_pow)) begin
            best <= rd_q;
            best_pow <= rd_pow;
            found <= 1'b1;
          end
        end
        if (state == lpfmd_pkg::StScan && state_next == lpfmd_pkg::StPick) begin
          now <= (earliest > base) ? earliest : base;
          cnt <= '0;
          found <= 1'b0;
        end
      end
      if (state == lpfmd_pkg::StWrite) begin
        arrived <= arrived + 1'b1;
        if (found) begin
          cur_time <= now;
          written[best] <= 1'b1;
          m_axis_tdata <= {4'b0, fin, now, lpfmd_pkg::IdxW'(best)};
          m_axis_tuser <= 1'b0;
        end else begin
          m_axis_tdata <= '0;
          m_axis_tuser <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/lpfmd_checker.sv
`timescale 1ns / 1ps
module lpfmd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser
);
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_nm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no_machine result has data");
  a_ord: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[99:52] >= m_axis_tdata[51:4])
    else $error("finish before start");
endmodule

bind lowest_power_free_machine_dispatcher_core lpfmd_checker u_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int NMach = 16;

  typedef struct packed {
    logic                        no_machine;
    logic [lpfmd_pkg::TimeW-1:0] finish_time;
    logic [lpfmd_pkg::TimeW-1:0] start_at;
    logic [lpfmd_pkg::IdxW-1:0]  machine;
  } dispatch_t;

  // Dispatcher state mirror and queue of expected assignments
  class dispatch_board;
    logic [lpfmd_pkg::PowerW-1:0] power_rank [NMach];
    logic                         enabled    [NMach];
    logic [lpfmd_pkg::TimeW-1:0]  free_at    [NMach];
    logic [lpfmd_pkg::TimeW-1:0]  now_time;
    logic [lpfmd_pkg::ArrW-1:0]   arrivals;
    dispatch_t                    pending[$];
    int                           mismatches;

    function new();
      for (int m = 0; m < NMach; m++) begin
        power_rank[m] = '0;
        enabled[m] = 1'b0;
        free_at[m] = '0;
      end
      now_time = '0;
      arrivals = '0;
      mismatches = 0;
    endfunction

    function void note_input(logic op, logic [lpfmd_pkg::IdxW-1:0] idx,
                             logic [lpfmd_pkg::PowerW-1:0] pwr,
                             logic en, logic [lpfmd_pkg::DurW-1:0] dur);
      dispatch_t                   d;
      logic [lpfmd_pkg::TimeW-1:0] earliest, t, arrival;
      logic [lpfmd_pkg::TimeW:0]   fin;
      bit                          any, found;
      int                          best;
      if (op == lpfmd_pkg::OpLoad) begin
        power_rank[idx] = pwr;
        enabled[idx] = en;
        return;
      end
      arrival = {{(lpfmd_pkg::TimeW-lpfmd_pkg::ArrW){1'b0}}, arrivals};
      arrivals++;
      any = 0;
      earliest = '0;
      for (int m = 0; m < NMach; m++)
        if (enabled[m]) begin
          if (!any || free_at[m] < earliest) earliest = free_at[m];
          any = 1;
        end
      d = '0;
      if (!any) begin
        d.no_machine = 1'b1;
        pending.push_back(d);
        return;
      end
      t = (now_time < arrival) ? arrival : now_time;
      if (earliest > t) t = earliest;
      found = 0;
      best = 0;
      for (int m = 0; m < NMach; m++)
        if (enabled[m] && free_at[m] <= t)
          if (!found || power_rank[m] < power_rank[best]) begin
            best = m;
            found = 1;
          end
      fin = {1'b0, t} + {{(lpfmd_pkg::TimeW+1-lpfmd_pkg::DurW){1'b0}}, dur};
      if (fin > {1'b0, lpfmd_pkg::TimeMax}) fin = {1'b0, lpfmd_pkg::TimeMax};
      now_time = t;
      free_at[best] = fin[lpfmd_pkg::TimeW-1:0];
      d.machine = best[lpfmd_pkg::IdxW-1:0];
      d.start_at = t;
      d.finish_time = fin[lpfmd_pkg::TimeW-1:0];
      pending.push_back(d);
    endfunction

    function void check_result(dispatch_t got);
      dispatch_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected mach=%0d start=%0d fin=%0d none=%0b, ",
                    "got mach=%0d start=%0d fin=%0d none=%0b"},
                   want.machine, want.start_at, want.finish_time, want.no_machine,
                   got.machine, got.start_at, got.finish_time, got.no_machine);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;

  dispatch_board board = new();
  bit            hold_sink = 0;
  bit            stim_done = 0;

  always #5 clk = ~clk;

  lowest_power_free_machine_dispatcher_core #(.NUM_MACHINES(NMach)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // record accepted transactions on both sides
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      board.note_input(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4],
                       s_axis_tdata[20], s_axis_tdata[36:21]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result({m_axis_tuser, m_axis_tdata[99:52], m_axis_tdata[51:4],
                          m_axis_tdata[3:0]});
  end

  // sink stall pattern
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) m_axis_tready <= 1'b0;
      else begin
        mode = $urandom_range(0, 9);
        m_axis_tready <= (mode < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  task automatic send_item(logic op, logic [lpfmd_pkg::IdxW-1:0] idx,
                           logic [lpfmd_pkg::PowerW-1:0] pwr,
                           logic en, logic [lpfmd_pkg::DurW-1:0] dur);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap_left > 0) s_axis_tvalid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b0, dur, en, pwr, idx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic load(int idx, int pwr, bit en);
    send_item(lpfmd_pkg::OpLoad, idx[lpfmd_pkg::IdxW-1:0], pwr[lpfmd_pkg::PowerW-1:0], en,
              lpfmd_pkg::DurW'($urandom()));
  endtask

  task automatic submit(int dur);
    send_item(lpfmd_pkg::OpTask, lpfmd_pkg::IdxW'($urandom()),
              lpfmd_pkg::PowerW'($urandom()), 1'($urandom()),
              dur[lpfmd_pkg::DurW-1:0]);
  endtask

  initial begin
    int sel;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // no machine enabled
    submit(5);
    submit(65535);
    // ties on power, lowest index wins
    load(3, 7, 1);
    load(9, 7, 1);
    submit(0);
    submit(100);
    submit(100);
    // extremes of power and index
    load(15, 0, 1);
    load(0, 65535, 1);
    submit(65535);
    submit(1);
    // reloading a busy machine keeps it busy
    load(15, 65535, 1);
    submit(3);
    // disable all
    for (int m = 0; m < NMach; m++) load(m, m, 0);
    submit(9);
    load(2, 1, 1);
    submit(65535);
    submit(65535);
    submit(0);

    // long receiver hold-off while input keeps coming
    fork
      begin
        hold_sink = 1;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 20; i++) submit($urandom_range(0, 50));
    join

    for (int i = 0; i < 1280; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) load($urandom_range(0, 15), $urandom(), $urandom_range(0, 7) != 0);
      else if (sel < 28) load($urandom_range(0, 15), $urandom(), 0);
      else if (sel < 33) submit(65535 - $urandom_range(0, 3));
      else submit($urandom_range(0, 40));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
